@@ design/rk4ss_pkg.sv @@
// ----------------------------------------------------------------------------
// rk4ss_pkg
// Shared widths, codes and saturation helpers for the linear state-space
// Runge-Kutta 4 integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package rk4ss_pkg;

  localparam int STATE_MAX       = 4;
  localparam int STATE_COUNT_DEF = 4;
  localparam int ROW_W           = 2;

  localparam int X_W       = 32;
  localparam int U_W       = 32;
  localparam int COEF_W    = 16;
  localparam int H_W       = 32;
  localparam int REG_W     = 64;
  localparam int CFG_IDX_W = 3;

  localparam int T_W   = 40;
  localparam int F_W   = 52;
  localparam int K_W   = 52;
  localparam int SUM_W = 56;
  localparam int TS_W  = 53;
  localparam int NS_W  = 57;

  localparam int MUL_A_W = 53;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = 70;
  localparam int ACC_W   = 70;
  localparam int FRAC_SH = 8;
  localparam int HALF_SH = 16;

  localparam logic [H_W-1:0] H_RESET = 32'd4294967;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A_ROW0     = 3'd0,
    CFG_A_ROW1     = 3'd1,
    CFG_A_ROW2     = 3'd2,
    CFG_A_ROW3     = 3'd3,
    CFG_B_COLUMN   = 3'd4,
    CFG_STEP_SIZE  = 3'd5
  } cfg_index_t;

  typedef enum logic [2:0] {
    MAC_NOP,
    MAC_LOAD,
    MAC_ADD,
    MAC_LOAD_SH,
    MAC_ADD_SH
  } mac_cmd_t;

  function automatic logic signed [T_W-1:0] sat_trial(input logic signed [TS_W-1:0] v);
    logic signed [T_W-1:0] r;
    if (!v[TS_W-1] && (|v[TS_W-2:T_W-1])) begin
      r = {1'b0, {(T_W-1){1'b1}}};
    end else if (v[TS_W-1] && !(&v[TS_W-2:T_W-1])) begin
      r = {1'b1, {(T_W-1){1'b0}}};
    end else begin
      r = v[T_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [X_W-1:0] sat_state(input logic signed [NS_W-1:0] v);
    logic signed [X_W-1:0] r;
    if (!v[NS_W-1] && (|v[NS_W-2:X_W-1])) begin
      r = {1'b0, {(X_W-1){1'b1}}};
    end else if (v[NS_W-1] && !(&v[NS_W-2:X_W-1])) begin
      r = {1'b1, {(X_W-1){1'b0}}};
    end else begin
      r = v[X_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/rk4ss_if.sv @@
// ----------------------------------------------------------------------------
// rk4ss_if
// Valid/ready channels of the integrator: plant input, updated state and
// register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rk4ss_in_if;
  import rk4ss_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [U_W-1:0] u_in;
  modport source (output valid, output u_in, input ready);
  modport sink (input valid, input u_in, output ready);
endinterface

interface rk4ss_out_if;
  import rk4ss_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [X_W-1:0] x0_out;
  logic signed [X_W-1:0] x1_out;
  logic signed [X_W-1:0] x2_out;
  logic signed [X_W-1:0] x3_out;
  modport source (output valid, output x0_out, output x1_out, output x2_out,
                  output x3_out, input ready);
  modport sink (input valid, input x0_out, input x1_out, input x2_out,
                input x3_out, output ready);
endinterface

interface rk4ss_cfg_if;
  import rk4ss_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REG_W-1:0]     wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

@@ design/rk4ss_mac.sv @@
// ----------------------------------------------------------------------------
// rk4ss_mac
// Shared signed multiplier with a registered product and a wide accumulator
// that can load or add, either plain or shifted down by sixteen bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rk4ss_mac (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rk4ss_pkg::mac_cmd_t                  cmd,
  input  logic signed [rk4ss_pkg::MUL_A_W-1:0] op_a,
  input  logic signed [rk4ss_pkg::MUL_B_W-1:0] op_b,
  output logic signed [rk4ss_pkg::ACC_W-1:0]   acc
);
  import rk4ss_pkg::*;

  logic signed [MUL_P_W-1:0] prod;
  logic signed [MUL_P_W-1:0] prod_r;
  mac_cmd_t                  cmd_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W:0]     acc_sum;

  assign prod    = op_a * op_b;
  assign acc_sum = $signed({acc_r[ACC_W-1], acc_r}) + $signed({prod_r[MUL_P_W-1], prod_r});
  assign acc     = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= MAC_NOP;
    end else begin
      cmd_r <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod;
    unique case (cmd_r)
      MAC_LOAD:    acc_r <= prod_r;
      MAC_ADD:     acc_r <= acc_r + prod_r;
      MAC_LOAD_SH: acc_r <= prod_r >>> HALF_SH;
      MAC_ADD_SH:  acc_r <= ACC_W'(acc_sum >>> HALF_SH);
      default:     acc_r <= acc_r;
    endcase
  end

endmodule

`default_nettype wire

@@ design/rk4ss_div6.sv @@
// ----------------------------------------------------------------------------
// rk4ss_div6
// Iterative signed division by six, truncating toward zero, one byte of the
// magnitude per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rk4ss_div6 (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [rk4ss_pkg::SUM_W-1:0] dividend,
  output logic                               done,
  output logic signed [rk4ss_pkg::SUM_W-1:0] quotient
);
  import rk4ss_pkg::*;

  localparam int DIGIT_W = 8;
  localparam int DIGITS  = SUM_W / DIGIT_W;
  localparam int CNT_W   = $clog2(DIGITS);
  localparam int REM_W   = 3;
  localparam int V_W     = REM_W + DIGIT_W;
  localparam int RECIP   = 683;
  localparam int RECIP_W = 10;
  localparam int RECIP_SH = 12;
  localparam int PR_W    = V_W + RECIP_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIGITS - 1);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               neg_r;
  logic [SUM_W-1:0]   mag_r;
  logic [REM_W-1:0]   rem_r;
  logic [SUM_W-1:0]   mag_in;
  logic [V_W-1:0]     v;
  logic [PR_W-1:0]    v_prod;
  logic [DIGIT_W-1:0] qd;
  logic [V_W-1:0]     qd6;
  logic [REM_W-1:0]   rem_nxt;

  assign mag_in  = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
  assign v       = {rem_r, mag_r[SUM_W-1 -: DIGIT_W]};
  assign v_prod  = PR_W'(v) * PR_W'(RECIP);
  assign qd      = v_prod[RECIP_SH +: DIGIT_W];
  assign qd6     = V_W'({qd, 2'b00}) + V_W'({qd, 1'b0});
  assign rem_nxt = REM_W'(v - qd6);

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(mag_r) : $signed(mag_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CNT_LAST);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        neg_r  <= dividend[SUM_W-1];
        mag_r  <= mag_in;
        rem_r  <= '0;
      end else if (busy_r) begin
        mag_r <= {mag_r[SUM_W-DIGIT_W-1:0], qd};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ design/rk4_linear_state_space_step.sv @@
// ----------------------------------------------------------------------------
// rk4_linear_state_space_step
// One classical Runge-Kutta 4 step of dx/dt = A*x + B*u per plant input word.
//
// Each word on in_chan carries u; the block advances its stored state x and
// sends the saturated new state as one word on out_chan. Registers are written
// through cfg_chan, which is always ready; write them only while idle.
// With N = STATE_COUNT, every slope row runs on the shared multiplier as B*u,
// N products of A with the trial point, one bubble and two half-width
// products with h. Four slopes of N rows are followed by one division by six
// per state element. One word is worked on at a time; in_chan.ready is high
// only while idle. The result sits in an output register, so the next word is
// taken as soon as it is loaded, even while the receiver stalls; a further
// result waits until the register is free.
// Reset clears the state vector to zero, A and B to zero and h to about 0.001.
// ----------------------------------------------------------------------------
`default_nettype none

module rk4_linear_state_space_step #(
  parameter int STATE_COUNT = rk4ss_pkg::STATE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rk4ss_in_if.sink    in_chan,
  rk4ss_out_if.source out_chan,
  rk4ss_cfg_if.sink   cfg_chan
);
  import rk4ss_pkg::*;

  localparam int STEP_W = $clog2(STATE_MAX + 5);
  localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(STATE_COUNT - 1);
  localparam logic [STEP_W-1:0] STEP_MAC = STEP_W'(STATE_COUNT);
  localparam logic [STEP_W-1:0] STEP_LO  = STEP_W'(STATE_COUNT + 2);
  localparam logic [STEP_W-1:0] STEP_HI  = STEP_W'(STATE_COUNT + 3);
  localparam logic [STEP_W-1:0] STEP_END = STEP_W'(STATE_COUNT + 4);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SLOPE,
    S_DRAIN,
    S_DIV_START,
    S_DIV_WAIT,
    S_OUT
  } seq_state_t;

  typedef enum logic [1:0] {
    PH_K1,
    PH_K2,
    PH_K3,
    PH_K4
  } phase_t;

  logic [REG_W-1:0] a_row_r [STATE_MAX];
  logic [REG_W-1:0] b_col_r;
  logic [H_W-1:0]   h_r;

  seq_state_t        state_r;
  phase_t            phase_r;
  logic [ROW_W-1:0]  row_r;
  logic [STEP_W-1:0] step_r;
  logic [ROW_W-1:0]  elem_r;
  logic              cap_r;
  logic [ROW_W-1:0]  cap_row_r;
  phase_t            cap_phase_r;
  logic              out_valid_r;

  logic signed [U_W-1:0]   u_r;
  logic signed [T_W-1:0]   t_r     [STATE_MAX];
  logic signed [T_W-1:0]   tn_r    [STATE_MAX];
  logic signed [SUM_W-1:0] sum_r   [STATE_MAX];
  logic signed [X_W-1:0]   x_r     [STATE_MAX];
  logic signed [X_W-1:0]   out_x_r [STATE_MAX];

  mac_cmd_t                  mac_cmd;
  logic signed [MUL_A_W-1:0] mac_a;
  logic signed [MUL_B_W-1:0] mac_b;
  logic signed [ACC_W-1:0]   mac_acc;
  logic [ROW_W-1:0]          col;
  logic [COEF_W-1:0]         coef_a;
  logic [COEF_W-1:0]         coef_b;
  logic signed [F_W-1:0]     f_val;

  logic [ROW_W-1:0]        sel_idx;
  logic signed [X_W-1:0]   x_sel;
  logic signed [K_W-1:0]   k_cap;
  logic signed [K_W-1:0]   k_half;
  logic signed [TS_W-1:0]  trial_sum;
  logic signed [T_W-1:0]   trial_sat;
  logic signed [SUM_W-1:0] sum_add;

  logic                    div_start;
  logic                    div_done;
  logic signed [SUM_W-1:0] div_q;
  logic signed [NS_W-1:0]  x_new;

  assign in_chan.ready   = (state_r == S_IDLE);
  assign cfg_chan.ready  = 1'b1;
  assign out_chan.valid  = out_valid_r;
  assign out_chan.x0_out = out_x_r[0];
  assign out_chan.x1_out = out_x_r[1];
  assign out_chan.x2_out = out_x_r[2];
  assign out_chan.x3_out = out_x_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < STATE_MAX; r++) begin
        a_row_r[r] <= '0;
      end
      b_col_r <= '0;
      h_r     <= H_RESET;
    end else if (cfg_chan.valid) begin
      unique case (cfg_index_t'(cfg_chan.index))
        CFG_A_ROW0:    a_row_r[0] <= cfg_chan.wdata;
        CFG_A_ROW1:    a_row_r[1] <= cfg_chan.wdata;
        CFG_A_ROW2:    a_row_r[2] <= cfg_chan.wdata;
        CFG_A_ROW3:    a_row_r[3] <= cfg_chan.wdata;
        CFG_B_COLUMN:  b_col_r    <= cfg_chan.wdata;
        CFG_STEP_SIZE: h_r        <= cfg_chan.wdata[H_W-1:0];
        default: ;
      endcase
    end
  end

  assign col    = ROW_W'(step_r - STEP_W'(1));
  assign coef_a = a_row_r[row_r][{col, 4'b0000} +: COEF_W];
  assign coef_b = b_col_r[{row_r, 4'b0000} +: COEF_W];
  assign f_val  = mac_acc[F_W+FRAC_SH-1:FRAC_SH];

  always_comb begin
    mac_cmd = MAC_NOP;
    mac_a   = '0;
    mac_b   = '0;
    if (state_r == S_SLOPE) begin
      priority if (step_r == '0) begin
        mac_cmd = MAC_LOAD;
        mac_a   = {{(MUL_A_W-U_W){u_r[U_W-1]}}, u_r};
        mac_b   = {coef_b[COEF_W-1], coef_b};
      end else if (step_r <= STEP_MAC) begin
        mac_cmd = MAC_ADD;
        mac_a   = {{(MUL_A_W-T_W){t_r[col][T_W-1]}}, t_r[col]};
        mac_b   = {coef_a[COEF_W-1], coef_a};
      end else if (step_r == STEP_LO) begin
        mac_cmd = MAC_LOAD_SH;
        mac_a   = {f_val[F_W-1], f_val};
        mac_b   = {1'b0, h_r[H_W/2-1:0]};
      end else if (step_r == STEP_HI) begin
        mac_cmd = MAC_ADD_SH;
        mac_a   = {f_val[F_W-1], f_val};
        mac_b   = {1'b0, h_r[H_W-1:H_W/2]};
      end else begin
        mac_cmd = MAC_NOP;
      end
    end
  end

  rk4ss_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mac_cmd),
    .op_a  (mac_a),
    .op_b  (mac_b),
    .acc   (mac_acc)
  );

  assign sel_idx   = (state_r == S_DIV_WAIT) ? elem_r : cap_row_r;
  assign x_sel     = x_r[sel_idx];
  assign k_cap     = mac_acc[K_W-1:0];
  assign k_half    = k_cap >>> 1;
  assign trial_sum = {{(TS_W-X_W){x_sel[X_W-1]}}, x_sel} +
                     ((cap_phase_r == PH_K3) ? {k_cap[K_W-1], k_cap} : {k_half[K_W-1], k_half});
  assign trial_sat = sat_trial(trial_sum);

  always_comb begin
    unique case (cap_phase_r)
      PH_K2, PH_K3: sum_add = {{(SUM_W-K_W-1){k_cap[K_W-1]}}, k_cap, 1'b0};
      default:      sum_add = {{(SUM_W-K_W){k_cap[K_W-1]}}, k_cap};
    endcase
  end

  assign div_start = (state_r == S_DIV_START);
  assign x_new     = {{(NS_W-X_W){x_sel[X_W-1]}}, x_sel} +
                     {{(NS_W-SUM_W){div_q[SUM_W-1]}}, div_q};

  rk4ss_div6 u_div6 (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r[elem_r]),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_K1;
      row_r       <= '0;
      step_r      <= '0;
      elem_r      <= '0;
      cap_r       <= 1'b0;
      cap_row_r   <= '0;
      cap_phase_r <= PH_K1;
      out_valid_r <= 1'b0;
      for (int r = 0; r < STATE_MAX; r++) begin
        x_r[r] <= '0;
      end
    end else begin
      cap_r <= (state_r == S_SLOPE) && (step_r == STEP_END);
      if ((state_r == S_OUT) && (!out_valid_r || out_chan.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      if (cap_r) begin
        if (cap_phase_r == PH_K1) begin
          sum_r[cap_row_r] <= sum_add;
        end else begin
          sum_r[cap_row_r] <= sum_r[cap_row_r] + sum_add;
        end
        tn_r[cap_row_r] <= trial_sat;
        if (cap_row_r == LAST_ROW) begin
          for (int r = 0; r < STATE_MAX; r++) begin
            t_r[r] <= (ROW_W'(r) == cap_row_r) ? trial_sat : tn_r[r];
          end
        end
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            u_r     <= in_chan.u_in;
            phase_r <= PH_K1;
            row_r   <= '0;
            step_r  <= '0;
            for (int r = 0; r < STATE_MAX; r++) begin
              t_r[r] <= {{(T_W-X_W){x_r[r][X_W-1]}}, x_r[r]};
            end
            state_r <= S_SLOPE;
          end
        end
        S_SLOPE: begin
          if (step_r == STEP_END) begin
            cap_row_r   <= row_r;
            cap_phase_r <= phase_r;
            step_r      <= '0;
            if (row_r == LAST_ROW) begin
              row_r <= '0;
              unique case (phase_r)
                PH_K1:   phase_r <= PH_K2;
                PH_K2:   phase_r <= PH_K3;
                PH_K3:   phase_r <= PH_K4;
                default: state_r <= S_DRAIN;
              endcase
            end else begin
              row_r <= row_r + ROW_W'(1);
            end
          end else begin
            step_r <= step_r + STEP_W'(1);
          end
        end
        S_DRAIN: begin
          elem_r  <= '0;
          state_r <= S_DIV_START;
        end
        S_DIV_START: begin
          state_r <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            x_r[elem_r] <= sat_state(x_new);
            if (elem_r == LAST_ROW) begin
              state_r <= S_OUT;
            end else begin
              elem_r  <= elem_r + ROW_W'(1);
              state_r <= S_DIV_START;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_chan.ready) begin
            for (int r = 0; r < STATE_MAX; r++) begin
              out_x_r[r] <= x_r[r];
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
